/* design/zmp_pkg.sv */
// Shared types and constants for the zipmap stream parser.
// Used by the top level, front end and back end; depends on nothing.
`timescale 1ns / 1ps

package zmp_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int MID_DEPTH_DEF   = 2;
  localparam int OUT_DEPTH_DEF   = 2;

  localparam logic [7:0] END_MARK = 8'hFF;
  localparam logic [7:0] BAD_MARK = 8'hFE;
  localparam logic [7:0] BIG_MARK = 8'hFD;

  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_PREFIX = 2'd1;
  localparam logic [1:0] ERR_NO_MAP = 2'd2;

  typedef struct packed {
    logic [7:0] data_in;
    logic       start_req;
  } item_t;

  typedef struct packed {
    logic [7:0]  data_out;
    logic [1:0]  kind;
    logic        first_of_string;
    logic        last_of_string;
    logic        empty_string;
    logic [31:0] string_length;
    logic [1:0]  error_code;
  } result_t;

  // Classified input byte, as queued between front and back.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       is_end;
    logic       is_bad;
    logic       is_big;
  } mid_word_t;

endpackage

/* design/zipmap_stream_parser.sv */
// Top level of the zipmap stream parser: front classifier, mid queue,
// parse back end and result queue. Depends on zmp_pkg, zmp_front,
// zmp_fifo and zmp_back.
//
// Usage:
//   Input channel is a queue write port: a byte word (data_in, start_req)
//   is taken at a clock edge with push high and full low. start_req marks
//   the count header of a new map and gives no result.
//   Result channel is a queue read port: while empty is low the oldest
//   result is on result; it is taken at an edge with pop high.
//   Each byte gives zero or one result word.
// Throughput: one byte per cycle, sustained, while results are popped;
//   the parse state machine decides each byte combinationally.
// Path: a taken byte is registered in the mid queue, decided by the back
//   end as it leaves that queue and registered in the result queue.
// Stall: when pop stays low the result queue fills, the back end halts,
//   then the mid queue fills and full rises. No word is lost.
// Reset: synchronous rst empties both queues and leaves no map open;
//   any byte without start_req then gives a no-map error.
`timescale 1ns / 1ps

module zipmap_stream_parser #(
  parameter int LENGTH_BITS = zmp_pkg::LENGTH_BITS_DEF,
  parameter int MID_DEPTH   = zmp_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH   = zmp_pkg::OUT_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  zmp_pkg::item_t   item,
  input  logic             pop,
  output logic             empty,
  output zmp_pkg::result_t result
);

  localparam int MID_W = $bits(zmp_pkg::mid_word_t);
  localparam int RES_W = $bits(zmp_pkg::result_t);

  zmp_pkg::mid_word_t front_word;
  zmp_pkg::mid_word_t mid_word;
  logic [MID_W-1:0]   mid_bits;
  logic               mid_empty;
  logic               out_full;
  logic               fire;
  logic               res_valid;
  zmp_pkg::result_t   res;
  logic [RES_W-1:0]   out_bits;

  zmp_front u_front (
    .item (item),
    .word (front_word)
  );

  zmp_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !full),
    .wr_data (front_word),
    .rd_en   (fire),
    .rd_data (mid_bits),
    .full    (full),
    .empty   (mid_empty)
  );

  assign mid_word = zmp_pkg::mid_word_t'(mid_bits);
  assign fire     = !mid_empty && !out_full;

  zmp_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .word      (mid_word),
    .res_valid (res_valid),
    .res       (res)
  );

  zmp_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fire && res_valid),
    .wr_data (res),
    .rd_en   (pop && !empty),
    .rd_data (out_bits),
    .full    (out_full),
    .empty   (empty)
  );

  assign result = zmp_pkg::result_t'(out_bits);

endmodule

/* design/zmp_fifo.sv */
// Small register queue of packed words.
// Generic; used by the top level for the mid and result queues.
`timescale 1ns / 1ps

module zmp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/zmp_front.sv */
// Front end: classifies each incoming byte against the prefix marks.
// Depends on zmp_pkg.
`timescale 1ns / 1ps

module zmp_front (
  input  zmp_pkg::item_t     item,
  output zmp_pkg::mid_word_t word
);

  always_comb begin
    word.data   = item.data_in;
    word.start  = item.start_req;
    word.is_end = (item.data_in == zmp_pkg::END_MARK);
    word.is_bad = (item.data_in == zmp_pkg::BAD_MARK);
    word.is_big = (item.data_in == zmp_pkg::BIG_MARK);
  end

endmodule

/* design/zmp_back.sv */
// Back end: parse state machine, one classified byte per cycle while fire is high.
// Depends on zmp_pkg.
`timescale 1ns / 1ps

module zmp_back #(
  parameter int LENGTH_BITS = zmp_pkg::LENGTH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  zmp_pkg::mid_word_t word,
  output logic               res_valid,
  output zmp_pkg::result_t   res
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_BIGLEN = 3'd2;
  localparam logic [2:0] PH_FREE   = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_PAD    = 3'd5;

  logic [2:0]             phase, phase_next;
  logic [31:0]            accum, accum_next;
  logic [1:0]             bcnt, bcnt_next;
  logic [LENGTH_BITS-1:0] remaining, remaining_next;
  logic [LENGTH_BITS-1:0] slen, slen_next;
  logic [7:0]             pad, pad_next;
  logic                   in_value, in_value_next;

  logic                   known;
  logic [LENGTH_BITS-1:0] known_len;
  logic [31:0]            big_full;
  logic                   big_ovf;
  logic [LENGTH_BITS-1:0] big_sat;

  always_comb begin
    big_full = accum | (32'(word.data) << {bcnt, 3'b000});
    big_ovf  = ((big_full >> LENGTH_BITS) != 32'd0);
    big_sat  = big_ovf ? '1 : big_full[LENGTH_BITS-1:0];
  end

  always_comb begin
    phase_next     = phase;
    accum_next     = accum;
    bcnt_next      = bcnt;
    remaining_next = remaining;
    slen_next      = slen;
    pad_next       = pad;
    in_value_next  = in_value;
    known          = 1'b0;
    known_len      = '0;
    res            = '0;
    res_valid      = 1'b0;

    if (word.start) begin
      // header (count) byte: restart, no result
      phase_next     = PH_LEN;
      in_value_next  = 1'b0;
      bcnt_next      = '0;
      remaining_next = '0;
      pad_next       = '0;
    end else if (phase == PH_IDLE) begin
      res_valid      = 1'b1;
      res.kind       = zmp_pkg::KIND_ERROR;
      res.error_code = zmp_pkg::ERR_NO_MAP;
    end else begin
      unique case (phase)
        PH_LEN: begin
          if (word.is_end && !in_value) begin
            phase_next     = PH_IDLE;
            in_value_next  = 1'b0;
            remaining_next = '0;
            pad_next       = '0;
            bcnt_next      = '0;
            res_valid      = 1'b1;
            res.kind       = zmp_pkg::KIND_END;
          end else if (word.is_end || word.is_bad) begin
            phase_next     = PH_IDLE;
            in_value_next  = 1'b0;
            remaining_next = '0;
            pad_next       = '0;
            bcnt_next      = '0;
            res_valid      = 1'b1;
            res.kind       = zmp_pkg::KIND_ERROR;
            res.error_code = zmp_pkg::ERR_PREFIX;
          end else if (word.is_big) begin
            accum_next = '0;
            bcnt_next  = '0;
            phase_next = PH_BIGLEN;
          end else begin
            known     = 1'b1;
            known_len = LENGTH_BITS'(word.data);
          end
        end
        PH_BIGLEN: begin
          // little-endian length, one byte lane per cycle while fire is high
          accum_next = big_full;
          bcnt_next  = bcnt + 2'd1;
          if (bcnt == 2'd3) begin
            known     = 1'b1;
            known_len = big_sat;
          end
        end
        PH_FREE: begin
          pad_next = word.data;
          if (remaining != '0) begin
            phase_next = PH_DATA;
          end else begin
            in_value_next = 1'b0;
            phase_next    = (word.data != 8'd0) ? PH_PAD : PH_LEN;
          end
        end
        PH_DATA: begin
          res_valid           = 1'b1;
          res.data_out        = word.data;
          res.kind            = in_value ? zmp_pkg::KIND_VALUE : zmp_pkg::KIND_KEY;
          res.first_of_string = (remaining == slen);
          res.last_of_string  = (remaining == LENGTH_BITS'(1));
          res.string_length   = 32'(slen);
          remaining_next      = remaining - 1'b1;
          if (remaining == LENGTH_BITS'(1)) begin
            if (in_value) begin
              in_value_next = 1'b0;
              phase_next    = (pad != 8'd0) ? PH_PAD : PH_LEN;
            end else begin
              in_value_next = 1'b1;
              phase_next    = PH_LEN;
            end
          end
        end
        PH_PAD: begin
          pad_next = pad - 8'd1;
          if (pad == 8'd1) begin
            phase_next = PH_LEN;
          end
        end
        default: begin
          phase_next     = PH_IDLE;
          in_value_next  = 1'b0;
          remaining_next = '0;
          pad_next       = '0;
          bcnt_next      = '0;
          res_valid      = 1'b1;
          res.kind       = zmp_pkg::KIND_ERROR;
          res.error_code = zmp_pkg::ERR_NO_MAP;
        end
      endcase

      if (known) begin
        slen_next      = known_len;
        remaining_next = known_len;
        if (in_value) begin
          phase_next = PH_FREE;
          if (known_len == '0) begin
            res_valid        = 1'b1;
            res.kind         = zmp_pkg::KIND_VALUE;
            res.empty_string = 1'b1;
          end
        end else if (known_len == '0) begin
          in_value_next    = 1'b1;
          phase_next       = PH_LEN;
          res_valid        = 1'b1;
          res.kind         = zmp_pkg::KIND_KEY;
          res.empty_string = 1'b1;
        end else begin
          phase_next = PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      bcnt      <= '0;
      remaining <= '0;
      pad       <= '0;
      in_value  <= 1'b0;
    end else if (fire) begin
      phase     <= phase_next;
      bcnt      <= bcnt_next;
      remaining <= remaining_next;
      pad       <= pad_next;
      in_value  <= in_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      accum <= accum_next;
      slen  <= slen_next;
    end
  end

`ifndef SYNTHESIS
  a_bcnt_only_biglen: assert property (@(posedge clk) disable iff (rst)
    bcnt != 2'd0 |-> phase == PH_BIGLEN)
    else $error("length byte count set outside big length phase");

  a_data_has_bytes: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> remaining != '0)
    else $error("data phase with no bytes left");

  a_pad_has_bytes: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAD |-> pad != 8'd0)
    else $error("padding phase with no padding left");

  a_key_end_to_value: assert property (@(posedge clk) disable iff (rst)
    fire && !word.start && phase == PH_DATA && !in_value &&
    remaining == LENGTH_BITS'(1) |=> phase == PH_LEN && in_value)
    else $error("key end did not switch to value length");

  a_idle_error: assert property (@(posedge clk) disable iff (rst)
    fire && !word.start && phase == PH_IDLE |->
    res_valid && res.error_code == zmp_pkg::ERR_NO_MAP)
    else $error("byte without open map not flagged");
`endif

endmodule
